[hw/rtl/r14pd_pkg.sv]
// ============================================================================
// r14pd_pkg
// Shared types, codes and constants of the r^(1/4) profile evaluator.
// ============================================================================
package r14pd_pkg;

   // Width of values in the base-2 logarithm domain, signed Q.32.
   localparam int LV_W   = 48;
   // Width of a 2^x mantissa, Q32 in [1, 2).
   localparam int MANT_W = 34;
   // Width of the integer part that comes out of a 2^x evaluation.
   localparam int EINT_W = 15;
   // Clamp of the 2^x argument, in integer units.
   localparam int EXP_BIAS = 8192;

   typedef logic signed [LV_W-1:0]   lv_type;
   typedef logic signed [EINT_W-1:0] eint_type;

   // Derivative orders.
   localparam logic [1:0] CMD_DENSITY = 2'd0;
   localparam logic [1:0] CMD_DERIV1  = 2'd1;
   localparam logic [1:0] CMD_DERIV2  = 2'd2;
   localparam logic [1:0] CMD_DERIV3  = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SAT   = 2'd1;
   localparam logic [1:0] ST_UNDEF = 2'd2;

   // Register indexes.
   localparam logic [0:0] CSR_TOTAL_MASS = 1'd0;
   localparam logic [0:0] CSR_EFF_RADIUS = 1'd1;

   // Constants in Q32.
   localparam logic [63:0] B_Q32     = 64'd32939175540;
   localparam logic [63:0] PI_Q32    = 64'h3_243F_6A89;
   localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
   localparam logic [63:0] LOG2E_Q32 = 64'h1_7154_7653;

   localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] radius;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
   } rsp_type;

   // Context of one item as it travels down the pipeline.
   typedef struct packed {
      logic        vld;
      logic [1:0]  k;
      logic        rz;
      logic        mz;
      lv_type      lt;
      lv_type      lz;
      lv_type      dk;
      lv_type      lb;
      logic [63:0] w;
   } ctx_type;

   // Base-2 logarithm of a constant, same algorithm as the log2 unit.
   function automatic logic [63:0] log2_const(input logic [63:0] x);
      logic [127:0] m;
      logic [127:0] sh;
      logic [31:0]  f;
      int           n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) n = i;
      end
      sh = ({64'd0, x} << 31) >> n;
      m  = {96'd0, sh[31:0]};
      f  = '0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         f = {f[30:0], 1'b0};
         if (m >= 128'h1_0000_0000) begin
            f[0] = 1'b1;
            m    = m >> 1;
         end
      end
      return (64'(n) << 32) | 64'(f);
   endfunction

   // log2 of Sigma0 = b^8 / (8! * pi), worked out at elaboration.
   localparam logic [63:0] LS0_FULL = 64'd8 * log2_const(B_Q32) - (64'd256 << 32)
                                    - log2_const(64'd40320)
                                    - (log2_const(PI_Q32) - (64'd32 << 32));
   localparam lv_type LS0 = lv_type'(LS0_FULL);

endpackage

[hw/rtl/r14pd_mul.sv]
// ============================================================================
// r14pd_mul
// Two-stage 64 x 64 multiplier giving floor(a*b / 2^32) modulo 2^64.
// ============================================================================
module r14pd_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum;
   logic [63:0]  p_ff;

   // Four 32 x 32 partial products.
   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= 64'(a[31:0])  * 64'(b[31:0]);
         p01_ff <= 64'(a[31:0])  * 64'(b[63:32]);
         p10_ff <= 64'(a[63:32]) * 64'(b[31:0]);
         p11_ff <= 64'(a[63:32]) * 64'(b[63:32]);
      end
   end

   assign sum = ({64'd0, p11_ff} << 64) + ({64'd0, p01_ff} << 32)
              + ({64'd0, p10_ff} << 32) + {64'd0, p00_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum[95:32];
      end
   end

   assign p = p_ff;

endmodule

[hw/rtl/r14pd_log2.sv]
// ============================================================================
// r14pd_log2
// Pipelined base-2 logarithm: normalise, then one squaring per stage.
// ============================================================================
module r14pd_log2 #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] x,
   output logic [37:0]  y
);

   localparam int NW = $clog2(W);

   logic [W-1:0]  x0_ff;
   logic [NW-1:0] n0_ff;
   logic [NW-1:0] n_in;
   logic [W+30:0] sh;
   logic [31:0]   m_ff [0:32];
   logic [31:0]   f_ff [0:32];
   logic [NW-1:0] n_ff [0:32];

   // Position of the top set bit.
   always_comb begin
      n_in = '0;
      for (int i = 0; i < W; i++) begin
         if (x[i]) n_in = NW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x;
         n0_ff <= n_in;
      end
   end

   // Mantissa into [2^31, 2^32).
   assign sh = {x0_ff, 31'd0} >> n0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= sh[31:0];
         f_ff[0] <= '0;
         n_ff[0] <= n0_ff;
      end
   end

   for (genvar i = 0; i < 32; i++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      assign sq = 64'(m_ff[i]) * 64'(m_ff[i]);
      assign t  = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i+1] <= t[32] ? t[32:1] : t[31:0];
            f_ff[i+1] <= {f_ff[i][30:0], t[32]};
            n_ff[i+1] <= n_ff[i];
         end
      end
   end

   assign y = {6'(n_ff[32]), f_ff[32]};

endmodule

[hw/rtl/r14pd_exp2.sv]
// ============================================================================
// r14pd_exp2
// Pipelined 2^x: clamp and split, then a twelve-term series for the fraction.
// ============================================================================
module r14pd_exp2
   import r14pd_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  lv_type            x,
   output logic [MANT_W-1:0] mant,
   output eint_type          ip
);

   localparam lv_type X_MAX = lv_type'(EXP_BIAS) <<< 32;

   lv_type      xc;
   lv_type      u;
   logic [31:0] f0_ff;
   eint_type    ip0_ff;
   logic [63:0] yprod;

   logic [32:0]       term_ff [0:12];
   logic [MANT_W-1:0] sum_ff  [0:12];
   logic [31:0]       y_ff    [0:12];
   eint_type          ip_ff   [0:12];

   always_comb begin
      xc = x;
      if (x < -X_MAX) xc = -X_MAX;
      if (x > X_MAX)  xc = X_MAX;
      u = xc + X_MAX;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_ff  <= u[31:0];
         ip0_ff <= eint_type'(u[46:32]) - eint_type'(EXP_BIAS);
      end
   end

   // Fraction times ln 2 is the argument of the series.
   assign yprod = 64'(f0_ff) * 64'(LN2_Q32);

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0]    <= yprod[63:32];
         ip_ff[0]   <= ip0_ff;
         term_ff[0] <= 33'h1_0000_0000;
         sum_ff[0]  <= MANT_W'(33'h1_0000_0000);
      end
   end

   for (genvar i = 0; i < 12; i++) begin : g_term
      localparam int NT = i + 1;
      localparam int LN = $clog2(NT);
      // Reciprocal that gives an exact floor division of a 32-bit value.
      localparam logic [33:0] RECIP = 34'(((66'd1 << (32 + LN)) + 66'(NT) - 66'd1) / NT);

      logic [64:0]       full;
      logic [65:0]       qprod;
      logic [31:0]       q;
      logic [31:0]       pm_ff;
      logic [31:0]       ym_ff;
      eint_type          ipm_ff;
      logic [MANT_W-1:0] summ_ff;

      assign full = 65'(term_ff[i]) * 65'(y_ff[i]);

      always_ff @(posedge clock) begin
         if (en) begin
            pm_ff   <= full[63:32];
            ym_ff   <= y_ff[i];
            ipm_ff  <= ip_ff[i];
            summ_ff <= sum_ff[i];
         end
      end

      assign qprod = 66'(pm_ff) * 66'(RECIP);
      assign q     = 32'(qprod >> (32 + LN));

      always_ff @(posedge clock) begin
         if (en) begin
            term_ff[i+1] <= 33'(q);
            sum_ff[i+1]  <= summ_ff + MANT_W'(q);
            y_ff[i+1]    <= ym_ff;
            ip_ff[i+1]   <= ipm_ff;
         end
      end
   end

   assign mant = sum_ff[12];
   assign ip   = ip_ff[12];

endmodule

[hw/rtl/r14pd_delay.sv]
// ============================================================================
// r14pd_delay
// Shift line that carries item context alongside a pipelined unit.
// ============================================================================
module r14pd_delay #(
   parameter int W = 8,
   parameter int D = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] dly_ff [0:D-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D; i++) dly_ff[i] <= '0;
      end else if (en) begin
         dly_ff[0] <= din;
         for (int i = 1; i < D; i++) dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign dout = dly_ff[D-1];

endmodule

[hw/rtl/r14_profile_density_eval.sv]
// ============================================================================
// r14_profile_density_eval
// r^(1/4) surface density profile and its first three radial derivatives.
// ============================================================================
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (cmd, radius)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (value, status)
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One request enters every clock cycle unless rsp_stall holds the pipeline.
// The path runs through two logarithm units (34 stages each) and two 2^x
// units (26 stages each), with multiplier and register stages between them.
// Reset is synchronous, clears every valid bit and sets the two registers to 1 << FRAC_BITS.
// When a result waits on rsp_stall the whole pipeline holds and req_stall
// rises in the same cycle, so nothing is dropped or repeated.
//
// The magnitude is worked out in the base-2 logarithm domain: log2 of the
// radius, the effective radius and the mass, then z = t^(1/4) through 2^x,
// then the polynomial of the derivative and its logarithm, and finally 2^L
// turned back into signed Q32.32 with saturation.
//
module r14_profile_density_eval
   import r14pd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int     LOG_LAT  = 34;
   localparam int     EXP_LAT  = 26;
   localparam int     MUL_LAT  = 2;
   localparam int     CTX_W    = $bits(ctx_type);
   localparam lv_type FRAC_LV  = lv_type'(FRAC_BITS) <<< 32;
   localparam lv_type MASS_OFS = LS0 - FRAC_LV;
   localparam lv_type OUT_OFS  = lv_type'(32) <<< 32;

   // Configuration registers.
   logic [47:0] mass_ff;
   logic [31:0] reff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= 48'd1 << FRAC_BITS;
         reff_ff <= 32'd1 << FRAC_BITS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_MASS: mass_ff <= csr_wdata;
            CSR_EFF_RADIUS: reff_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Entry stage.
   ctx_type     s0_ctx_in, s0_ctx_ff;
   logic [31:0] s0_r_ff, s0_re_ff;
   logic [47:0] s0_m_ff;

   always_comb begin
      s0_ctx_in     = '0;
      s0_ctx_in.vld = req_valid;
      s0_ctx_in.k   = req_data.cmd;
      s0_ctx_in.rz  = (req_data.radius == 32'd0);
      s0_ctx_in.mz  = (mass_ff == 48'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) s0_ctx_ff <= '0;
      else if (adv) s0_ctx_ff <= s0_ctx_in;
   end

   // A zero effective radius counts as one least significant bit.
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_r_ff  <= req_data.radius;
         s0_re_ff <= (reff_ff == 32'd0) ? 32'd1 : reff_ff;
         s0_m_ff  <= mass_ff;
      end
   end

   // Logarithms of radius, effective radius and mass.
   logic [37:0] lr, lre, lm;
   ctx_type     c1;

   r14pd_log2 #(.W(32)) u_log_r  (.clock(clock), .en(adv), .x(s0_r_ff),  .y(lr));
   r14pd_log2 #(.W(32)) u_log_re (.clock(clock), .en(adv), .x(s0_re_ff), .y(lre));
   r14pd_log2 #(.W(48)) u_log_m  (.clock(clock), .en(adv), .x(s0_m_ff),  .y(lm));
   r14pd_delay #(.W(CTX_W), .D(LOG_LAT)) u_dly_log (
      .clock(clock), .reset(reset), .en(adv), .din(s0_ctx_ff), .dout(c1));

   // Stage A: log t, and the mass and radius terms.
   ctx_type sa_ctx_in, sa_ctx_ff;
   lv_type  sa_lmk_ff, sa_are_ff;

   always_comb begin
      sa_ctx_in    = c1;
      sa_ctx_in.lt = c1.rz ? '0 : lv_type'(lr) - lv_type'(lre);
   end

   always_ff @(posedge clock) begin
      if (reset) sa_ctx_ff <= '0;
      else if (adv) sa_ctx_ff <= sa_ctx_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_lmk_ff <= lv_type'(lm) + MASS_OFS;
         sa_are_ff <= lv_type'(lre) - FRAC_LV;
      end
   end

   // Stage B: log z = log t / 4 rounded toward zero, and the base exponent
   // Mtot * Sigma0 / Reff^(2+k).
   ctx_type sb_ctx_in, sb_ctx_ff;
   lv_type  lt_adj, are_k;

   always_comb begin
      lt_adj = sa_ctx_ff.lt + (sa_ctx_ff.lt[LV_W-1] ? lv_type'(3) : lv_type'(0));
      case (sa_ctx_ff.k)
         CMD_DENSITY: are_k = sa_are_ff <<< 1;
         CMD_DERIV1:  are_k = (sa_are_ff <<< 1) + sa_are_ff;
         CMD_DERIV2:  are_k = sa_are_ff <<< 2;
         default:     are_k = (sa_are_ff <<< 2) + sa_are_ff;
      endcase
      sb_ctx_in    = sa_ctx_ff;
      sb_ctx_in.lz = lt_adj >>> 2;
      sb_ctx_in.lb = sa_lmk_ff - are_k;
   end

   always_ff @(posedge clock) begin
      if (reset) sb_ctx_ff <= '0;
      else if (adv) sb_ctx_ff <= sb_ctx_in;
   end

   // z = 2^(log z).
   logic [MANT_W-1:0] zm;
   eint_type          zi;
   ctx_type           c2;

   r14pd_exp2 u_exp_z (.clock(clock), .en(adv), .x(sb_ctx_ff.lz), .mant(zm), .ip(zi));
   r14pd_delay #(.W(CTX_W), .D(EXP_LAT)) u_dly_expz (
      .clock(clock), .reset(reset), .en(adv), .din(sb_ctx_ff), .dout(c2));

   // Stage C: z in Q32 and the derivative term log z - k log t.
   ctx_type     sc_ctx_in, sc_ctx_ff;
   logic [63:0] sc_z_in, sc_z_ff;
   lv_type      klt;
   eint_type    zneg;

   always_comb begin
      case (c2.k)
         CMD_DENSITY: klt = '0;
         CMD_DERIV1:  klt = c2.lt;
         CMD_DERIV2:  klt = c2.lt <<< 1;
         default:     klt = (c2.lt <<< 1) + c2.lt;
      endcase
      sc_ctx_in    = c2;
      sc_ctx_in.dk = c2.lz - klt;
      zneg         = -zi;
      if (c2.rz)         sc_z_in = '0;
      else if (!zi[EINT_W-1]) sc_z_in = 64'(zm) << zi[3:0];
      else               sc_z_in = 64'(zm) >> zneg[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) sc_ctx_ff <= '0;
      else if (adv) sc_ctx_ff <= sc_ctx_in;
   end

   always_ff @(posedge clock) begin
      if (adv) sc_z_ff <= sc_z_in;
   end

   // w = b * z.
   logic [63:0] w_mul;
   ctx_type     c3, c3w;

   r14pd_mul u_mul_w (.clock(clock), .en(adv), .a(B_Q32), .b(sc_z_ff), .p(w_mul));
   r14pd_delay #(.W(CTX_W), .D(MUL_LAT)) u_dly_w (
      .clock(clock), .reset(reset), .en(adv), .din(sc_ctx_ff), .dout(c3));

   always_comb begin
      c3w   = c3;
      c3w.w = w_mul;
   end

   // w * log2(e) for the exponential, and w * w for the third derivative.
   logic [63:0] elw, ww;
   ctx_type     c4;

   r14pd_mul u_mul_e  (.clock(clock), .en(adv), .a(w_mul), .b(LOG2E_Q32), .p(elw));
   r14pd_mul u_mul_ww (.clock(clock), .en(adv), .a(w_mul), .b(w_mul),     .p(ww));
   r14pd_delay #(.W(CTX_W), .D(MUL_LAT)) u_dly_e (
      .clock(clock), .reset(reset), .en(adv), .din(c3w), .dout(c4));

   // Stage D: polynomial argument and the exponential term.
   ctx_type     sd_ctx_in, sd_ctx_ff;
   logic [63:0] sd_s_in, sd_s_ff;

   always_comb begin
      sd_ctx_in    = c4;
      sd_ctx_in.lb = c4.lb - lv_type'(elw);
      if (c4.k == CMD_DERIV3) sd_s_in = (64'd21 << 32) + (c4.w << 3) + c4.w + ww;
      else                    sd_s_in = (64'd3 << 32) + c4.w;
   end

   always_ff @(posedge clock) begin
      if (reset) sd_ctx_ff <= '0;
      else if (adv) sd_ctx_ff <= sd_ctx_in;
   end

   always_ff @(posedge clock) begin
      if (adv) sd_s_ff <= sd_s_in;
   end

   logic [63:0] pr;
   ctx_type     c5;

   r14pd_mul u_mul_p (.clock(clock), .en(adv), .a(B_Q32), .b(sd_s_ff), .p(pr));
   r14pd_delay #(.W(CTX_W), .D(MUL_LAT)) u_dly_p (
      .clock(clock), .reset(reset), .en(adv), .din(sd_ctx_ff), .dout(c5));

   // Stage E: the polynomial of the chosen derivative. The density needs
   // none, so a harmless one feeds the logarithm.
   ctx_type     se_ctx_ff;
   logic [63:0] se_p_in, se_p_ff;

   always_comb begin
      case (c5.k)
         CMD_DERIV1: se_p_in = B_Q32 >> 2;
         CMD_DERIV2: se_p_in = pr >> 4;
         CMD_DERIV3: se_p_in = pr >> 6;
         default:    se_p_in = 64'd1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) se_ctx_ff <= '0;
      else if (adv) se_ctx_ff <= c5;
   end

   always_ff @(posedge clock) begin
      if (adv) se_p_ff <= se_p_in;
   end

   logic [37:0] lp;
   ctx_type     c6;

   r14pd_log2 #(.W(64)) u_log_p (.clock(clock), .en(adv), .x(se_p_ff), .y(lp));
   r14pd_delay #(.W(CTX_W), .D(LOG_LAT)) u_dly_logp (
      .clock(clock), .reset(reset), .en(adv), .din(se_ctx_ff), .dout(c6));

   // Stage F: exponent of the result in Q32.32, that is L + 32.
   ctx_type sf_ctx_ff;
   lv_type  sf_x_in, sf_x_ff;

   always_comb begin
      if (c6.k != CMD_DENSITY) sf_x_in = c6.lb + lv_type'(lp) + c6.dk;
      else                     sf_x_in = c6.lb + OUT_OFS;
   end

   always_ff @(posedge clock) begin
      if (reset) sf_ctx_ff <= '0;
      else if (adv) sf_ctx_ff <= c6;
   end

   always_ff @(posedge clock) begin
      if (adv) sf_x_ff <= sf_x_in;
   end

   logic [MANT_W-1:0] mant;
   eint_type          xi;
   ctx_type           c7;

   r14pd_exp2 u_exp_out (.clock(clock), .en(adv), .x(sf_x_ff), .mant(mant), .ip(xi));
   r14pd_delay #(.W(CTX_W), .D(EXP_LAT)) u_dly_expo (
      .clock(clock), .reset(reset), .en(adv), .din(sf_ctx_ff), .dout(c7));

   // Stage H: scale the mantissa by its integer part; bits below the
   // binary point of Q32.32 are dropped.
   ctx_type     sh_ctx_ff;
   logic [63:0] sh_mag_in, sh_mag_ff;
   logic        sh_sat_ff;
   eint_type    xl, xr;

   always_comb begin
      xl = xi - eint_type'(32);
      xr = eint_type'(32) - xi;
      if (xi >= eint_type'(32))      sh_mag_in = 64'(mant) << xl[4:0];
      else if (xr > eint_type'(33))  sh_mag_in = '0;
      else                           sh_mag_in = 64'(mant) >> xr[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) sh_ctx_ff <= '0;
      else if (adv) sh_ctx_ff <= c7;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sh_mag_ff <= sh_mag_in;
         sh_sat_ff <= (xi > eint_type'(62));
      end
   end

   // Output register: special cases, sign and saturation.
   rsp_type rsp_in, rsp_data_ff;

   always_comb begin
      if (sh_ctx_ff.rz && sh_ctx_ff.k != CMD_DENSITY) begin
         rsp_in.value  = '0;
         rsp_in.status = ST_UNDEF;
      end else if (sh_ctx_ff.mz) begin
         rsp_in.value  = '0;
         rsp_in.status = ST_OK;
      end else if (sh_sat_ff) begin
         rsp_in.value  = sh_ctx_ff.k[0] ? SAT_NEG : SAT_POS;
         rsp_in.status = ST_SAT;
      end else begin
         rsp_in.value  = sh_ctx_ff.k[0] ? (64'd0 - sh_mag_ff) : sh_mag_ff;
         rsp_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= sh_ctx_ff.vld;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/r14pd_chk.sv]
// ============================================================================
// r14pd_chk
// Port-level checks of the profile evaluator, bound to the top level.
// ============================================================================
module r14pd_chk
   import r14pd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Requests are held back only by a stalled result.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   // An undefined derivative carries a zero value.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_UNDEF |-> rsp_data.value == 64'd0)
      else $error("undefined status with nonzero value");

   // A saturated result is one of the two extremes.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SAT |->
         rsp_data.value == SAT_POS || rsp_data.value == SAT_NEG)
      else $error("saturated status with a value short of full scale");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind r14_profile_density_eval r14pd_chk u_chk (.*);

[sim/r14_profile_density_eval_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// r14_profile_density_eval_tb
// Self-checking bench for the r^(1/4) profile and derivative evaluator.
// ============================================================================
// A driver and a monitor run as clocked processes. The stimulus process
// fills a queue of pending requests. It runs a directed set first, then
// randomised phases under several mass and effective radius settings.
// Every accepted request is run through a bit-exact integer model of the
// logarithm-domain datapath, and the result is queued for the monitor.
// ============================================================================
module r14_profile_density_eval_tb
   import r14pd_pkg::*;
();

   localparam int    FRACB      = 16;
   localparam int    HOLD_LEN   = 600;
   localparam int    LIMIT      = 400000;
   localparam longint ONE       = longint'(1) << 32;
   localparam longint BIAS      = longint'(8192) << 32;
   localparam longint unsigned LOW    = 64'hFFFF_FFFF;
   localparam longint unsigned K_B    = 64'd32939175540;
   localparam longint unsigned K_PI   = 64'h3_243F_6A89;
   localparam longint unsigned K_LN2  = 64'hB172_17F8;
   localparam longint unsigned K_L2E  = 64'h1_7154_7653;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [47:0] csr_wdata;

   // The bench's own copy of the two registers, as the block should hold them.
   logic [47:0] mass_reg;
   logic [31:0] reff_reg;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      fail_count;
   int      hold_requests;
   int      cycle_count;

   r14_profile_density_eval #(.FRAC_BITS(FRACB)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Integer model of the evaluator.
   // ------------------------------------------------------------------------

   // Bits 95:32 of the full 128-bit product, that is the Q32 product modulo 2^64.
   function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   // Base-2 logarithm in signed Q32 by repeated squaring of the mantissa.
   function automatic longint log2_q32(longint unsigned x);
      int              n;
      longint unsigned m;
      longint unsigned f;
      n = 63;
      while (n > 0 && x[n] == 1'b0) n--;
      m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      f = 0;
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         f = f << 1;
         if (m >= 64'h1_0000_0000) begin
            f = f | 1;
            m = m >> 1;
         end
      end
      return longint'(n) * ONE + longint'(f);
   endfunction

   // 2^x for signed Q32 x: returns the Q32 mantissa and the integer part.
   function automatic longint unsigned pow2_q32(longint x, output longint ipart);
      longint unsigned u;
      longint unsigned y;
      longint unsigned sum;
      longint unsigned term;
      if (x < -BIAS) x = -BIAS;
      if (x > BIAS) x = BIAS;
      u = longint'(x + BIAS);
      ipart = longint'(u >> 32) - 8192;
      y = mul_q32(u & LOW, K_LN2);
      sum = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      for (int n = 1; n <= 12; n++) begin
         term = mul_q32(term, y) / n;
         sum = sum + term;
      end
      return sum;
   endfunction

   function automatic rsp_type profile_value(req_type rq, logic [47:0] mass,
                                             logic [31:0] reff);
      rsp_type         rs;
      int              k;
      longint unsigned re;
      longint unsigned w;
      longint unsigned zm;
      longint unsigned z;
      longint unsigned p;
      longint unsigned mant;
      longint unsigned mag;
      longint          lt;
      longint          lz;
      longint          lre;
      longint          ls0;
      longint          big_l;
      longint          zi;
      longint          xi;
      k = rq.cmd;
      rs.value = '0;
      rs.status = ST_OK;
      lt = 0;
      lz = 0;
      w = 0;
      // A derivative at the centre has no finite value.
      if (rq.radius == 0 && rq.cmd != CMD_DENSITY) begin
         rs.status = ST_UNDEF;
         return rs;
      end
      if (mass == 0) return rs;
      re = (reff == 0) ? 64'd1 : {32'd0, reff};
      lre = log2_q32(re);
      if (rq.radius != 0) begin
         lt = log2_q32({32'd0, rq.radius}) - lre;
         lz = lt / 4;
         zm = pow2_q32(lz, zi);
         z = (zi >= 0) ? (zm << zi) : (zm >> (-zi));
         w = mul_q32(K_B, z);
      end
      ls0 = 8 * log2_q32(K_B) - 256 * ONE - log2_q32(64'd40320)
            - (log2_q32(K_PI) - 32 * ONE);
      big_l = log2_q32({16'd0, mass}) - longint'(FRACB) * ONE
              - longint'(2 + k) * (lre - longint'(FRACB) * ONE)
              + ls0 - longint'(mul_q32(w, K_L2E));
      if (rq.cmd != CMD_DENSITY) begin
         if (rq.cmd == CMD_DERIV1) p = K_B >> 2;
         else if (rq.cmd == CMD_DERIV2) p = mul_q32(K_B, (64'd3 << 32) + w) >> 4;
         else p = mul_q32(K_B, (64'd21 << 32) + 9 * w + mul_q32(w, w)) >> 6;
         big_l = big_l + log2_q32(p) - 32 * ONE + lz - longint'(k) * lt;
      end
      mant = pow2_q32(big_l + 32 * ONE, xi);
      if (xi >= 63) begin
         rs.value = rq.cmd[0] ? SAT_NEG : SAT_POS;
         rs.status = ST_SAT;
         return rs;
      end
      if (xi >= 32) mag = mant << (xi - 32);
      else if (32 - xi >= 64) mag = 0;
      else mag = mant >> (32 - xi);
      rs.value = rq.cmd[0] ? (64'd0 - mag) : mag;
      return rs;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: sends pending requests in bursts of random length separated by
   // random gaps. A request that is stalled is held unchanged.
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 4;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(profile_value(req_data, mass_reg, reff_reg));
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
               if (burst_left <= 1) begin
                  // Mostly short gaps, now and then a longer one.
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(5, 30)
                                                          : $urandom_range(0, 3);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver and monitor. The stall pattern changes mode now and then; a
   // long hold-off can be requested by the stimulus process.
   // ------------------------------------------------------------------------
   int stall_mode;
   int mode_left;
   int hold_left;
   int holds_done;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         mode_left <= 50;
         hold_left <= 0;
         holds_done <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%t: result with none expected: value %h status %0d",
                        $time, rsp_data.value, rsp_data.status);
               fail_count = fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.value !== want.value) begin
                  $display("%t: value mismatch: expected %h, actual %h",
                           $time, want.value, rsp_data.value);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (holds_done < hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 3);
               mode_left <= $urandom_range(20, 200);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= (mode_left % 5 < 2);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("r14_profile_density_eval_tb NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [0:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TOTAL_MASS) mass_reg = val;
      else reff_reg = val[31:0];
   endtask

   // Waits until every request has gone and every result has come back, then
   // lets the pipeline settle before anything is changed.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (150) @(negedge clock);
   endtask

   task automatic queue_req(logic [1:0] cmd, logic [31:0] radius);
      req_type rq;
      rq.cmd = cmd;
      rq.radius = radius;
      pending_reqs.push_back(rq);
   endtask

   // Radii spread over the whole range, with weight near the effective radius
   // where the profile changes fastest.
   function automatic logic [31:0] pick_radius();
      int sh;
      sh = $urandom_range(0, 12);
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return $urandom_range(1, 255);
         3, 4:    return reff_reg >> sh;
         5, 6:    return (reff_reg << sh) | $urandom_range(0, 15);
         7:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         8:       return ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 1 << 20);
         default: return $urandom_range(32'h8000, 32'h40000);
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) queue_req($urandom_range(0, 3), pick_radius());
   endtask

   logic [47:0] mass_pick;
   logic [31:0] reff_pick;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TOTAL_MASS;
      csr_wdata = '0;
      fail_count = 0;
      hold_requests = 0;
      cycle_count = 0;
      mass_reg = 48'h1_0000;
      reff_reg = 32'h1_0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset values: centre, smallest and largest
      // radius, the effective radius itself, for every derivative order.
      for (int c = 0; c < 4; c++) begin
         queue_req(c[1:0], 32'd0);
         queue_req(c[1:0], 32'd1);
         queue_req(c[1:0], 32'h1_0000);
         queue_req(c[1:0], 32'hFFFF_FFFF);
      end
      wait_drained();

      // Heaviest mass with the smallest effective radius drives the value
      // into saturation of both signs.
      write_reg(CSR_TOTAL_MASS, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_EFF_RADIUS, 32'd1);
      for (int c = 0; c < 4; c++) queue_req(c[1:0], 32'd2);
      queue_req(CMD_DENSITY, 32'd0);
      wait_drained();

      // Zero mass, and a zero effective radius which counts as one step.
      write_reg(CSR_TOTAL_MASS, 48'd0);
      write_reg(CSR_EFF_RADIUS, 32'd0);
      queue_req(CMD_DENSITY, 32'h1_0000);
      queue_req(CMD_DERIV3, 32'h1234);
      wait_drained();
      write_reg(CSR_TOTAL_MASS, 48'h1_0000);
      queue_req(CMD_DERIV1, 32'd7);
      queue_req(CMD_DERIV2, 32'hFFFF_FFFF);
      wait_drained();

      // Randomised phases, each under its own register setting; the first two
      // take the extremes of both registers and the third their reset values.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin mass_pick = 48'hFFFF_FFFF_FFFF; reff_pick = 32'hFFFF_FFFF; end
            1: begin mass_pick = 48'd1;              reff_pick = 32'd1;         end
            2: begin mass_pick = 48'h1_0000;         reff_pick = 32'h1_0000;    end
            default: begin
               mass_pick = 48'({$urandom, $urandom} >> $urandom_range(0, 40));
               reff_pick = $urandom >> $urandom_range(0, 24);
            end
         endcase
         write_reg(CSR_TOTAL_MASS, mass_pick);
         write_reg(CSR_EFF_RADIUS, reff_pick);
         random_phase(80);
         if (ph == 3) begin
            // Long hold-off at the receiver while requests keep coming, so
            // that the pipeline fills and pushes back on its input.
            @(negedge clock);
            hold_requests = hold_requests + 1;
         end
         if (ph == 5) begin
            // Sender waits for the pipeline to empty before going on.
            wait_drained();
         end
         random_phase(controlled_count(ph));
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("r14_profile_density_eval_tb OK");
      end else begin
         $display("r14_profile_density_eval_tb NOT OK");
      end
      $finish;
   end

   // Later phases carry most of the random load.
   function automatic int controlled_count(int ph);
      return (ph < 3) ? 60 : 110;
   endfunction

endmodule
